// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// shared widths, token and status codes, and the arithmetic unit interface
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 128;

  localparam int CMD_W     = 3;
  localparam int OPERAND_W = 16;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int DEPTH_W   = 8;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 48;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd5;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

endpackage

// File: sv/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu
// Q16.16 add, subtract, multiply and divide on one shared 34-bit adder,
// multiply by shift-add and divide by restoring steps, all saturating
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic                                clk,
  input  logic                                rst,
  input  pse_pkg::alu_ctrl_t                  ctrl,
  input  logic signed [pse_pkg::VALUE_W-1:0]  a,
  input  logic signed [pse_pkg::VALUE_W-1:0]  b,
  output logic                                done,
  output logic signed [pse_pkg::VALUE_W-1:0]  result
);

  import pse_pkg::*;

  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 48;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ADD,
    A_MUL,
    A_MFIX,
    A_DIV,
    A_DFIX
  } state_t;

  state_t             state;
  alu_op_t            op;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic               neg;
  logic [5:0]         cnt;
  logic [31:0]        hi;
  logic [31:0]        lo;
  logic [31:0]        mcand;
  logic [31:0]        rem;
  logic [47:0]        num;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [33:0] x;
  logic [33:0] y;
  logic        sub;
  logic [33:0] sum;
  logic signed [31:0] add_sat;
  logic [63:0]        prod;
  logic signed [63:0] prod_sh;
  logic signed [31:0] mul_sat;
  logic [47:0]        quo_neg;
  logic signed [31:0] div_sat;

  assign mag_a = a[31] ? (~a + 32'd1) : a;
  assign mag_b = b[31] ? (~b + 32'd1) : b;

  // operand steering into the one adder
  always_comb begin
    x   = '0;
    y   = '0;
    sub = 1'b0;
    case (state)
      A_ADD: begin
        x   = {{2{opa[31]}}, opa};
        y   = {{2{opb[31]}}, opb};
        sub = (op == ALU_SUB);
      end
      A_MUL: begin
        x = {2'b00, hi};
        y = lo[0] ? {2'b00, mcand} : '0;
      end
      A_DIV: begin
        x   = {1'b0, rem, num[47]};
        y   = {2'b00, mcand};
        sub = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
  end

  assign sum = x + (sub ? ~y : y) + 34'(sub);

  assign add_sat = (sum[32] != sum[31]) ? (sum[32] ? SAT_MIN : SAT_MAX) : sum[31:0];

  // arithmetic shift of the signed product is the floor division by 2^16
  assign prod    = neg ? (~{hi, lo} + 64'd1) : {hi, lo};
  assign prod_sh = $signed(prod) >>> 16;
  assign mul_sat = ((&prod_sh[63:31]) || !(|prod_sh[63:31])) ? prod_sh[31:0] :
                   (prod_sh[63] ? SAT_MIN : SAT_MAX);

  assign quo_neg = ~num + 48'd1;
  always_comb begin
    if (neg) begin
      div_sat = (num > 48'h0000_8000_0000) ? SAT_MIN : quo_neg[31:0];
    end else begin
      div_sat = (num > 48'h0000_7FFF_FFFF) ? SAT_MAX : num[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (ctrl.start) begin
            opa   <= a;
            opb   <= b;
            op    <= ctrl.op;
            neg   <= a[31] ^ b[31];
            cnt   <= '0;
            mcand <= mag_b;
            case (ctrl.op)
              ALU_MUL: begin
                hi    <= '0;
                lo    <= mag_a;
                state <= A_MUL;
              end
              ALU_DIV: begin
                rem   <= '0;
                num   <= {mag_a, 16'd0};
                state <= A_DIV;
              end
              default: begin
                state <= A_ADD;
              end
            endcase
          end
        end
        A_ADD: begin
          result <= add_sat;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_MUL: begin
          hi  <= sum[32:1];
          lo  <= {sum[0], lo[31:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(MUL_STEPS - 1)) begin
            state <= A_MFIX;
          end
        end
        A_MFIX: begin
          result <= mul_sat;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_DIV: begin
          // a nonnegative trial difference means the divisor fits
          if (!sum[33]) begin
            rem <= sum[31:0];
          end else begin
            rem <= {rem[30:0], num[47]};
          end
          num <= {num[46:0], !sum[33]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) begin
            state <= A_DFIX;
          end
        end
        A_DFIX: begin
          result <= div_sat;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/postfix_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// postfix token evaluator on a Q16.16 operand stack with error latching
// ----------------------------------------------------------------------------
// Takes one token per request (push, add, subtract, multiply, divide) and
// returns one result per token: the top of stack, the first error of the
// expression so far, the depth, and tlast on the token that closes the
// expression. The block holds one token at a time. A push, an invalid token
// or a token that raises an error goes through exec and finish before the next
// ready; an operator also goes through load and calc, where multiply and divide
// wait on the bit-serial loops of the shared adder in the arithmetic unit.
// The stack lives in a one-write, one-read memory with the top entry also
// held in a register; no clearing pass is needed after reset.
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pse_pkg::S_DATA_W-1:0]  s_tdata,   // cmd[2:0], operand[18:3], zero pad
  input  logic                          s_tlast,   // last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pse_pkg::M_DATA_W-1:0]  m_tdata,   // value[31:0], status[34:32], depth[42:35]
  output logic                          m_tlast    // done_res
);

  import pse_pkg::*;

  `include "assert_macros.svh"

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_CALC,
    S_FINISH
  } state_t;

  state_t                       state;
  logic [CMD_W-1:0]             cmd_r;
  logic signed [OPERAND_W-1:0]  operand_r;
  logic                         last_r;
  logic [CW-1:0]                count;
  logic [VALUE_W-1:0]           tos;
  logic [STATUS_W-1:0]          err_latch;

  logic [VALUE_W-1:0]  value_o;
  logic [STATUS_W-1:0] status_o;
  logic [DEPTH_W-1:0]  depth_o;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;

  alu_ctrl_t          alu_ctrl;
  logic               alu_done;
  logic [VALUE_W-1:0] alu_result;

  logic               full;
  logic               ops_ok;
  logic               out_free;
  logic [VALUE_W-1:0] push_val;
  logic [STATUS_W-1:0] fin_status;
  logic [VALUE_W-1:0]  fin_value;
  logic [DEPTH_W-1:0]  fin_depth;

  function automatic logic [STATUS_W-1:0] flag(input logic [STATUS_W-1:0] cur,
                                               input logic [STATUS_W-1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {5'd0, depth_o, status_o, value_o};

  assign full     = (count == CW'(STACK_DEPTH));
  assign ops_ok   = (count >= CW'(2));
  assign out_free = !m_tvalid || m_tready;
  assign push_val = {operand_r, 16'd0};

  // stack memory access: push writes at count, an operator reads and
  // rewrites the entry under the top
  always_comb begin
    wr_en   = ((state == S_EXEC) && (cmd_r == CMD_PUSH) && !full) ||
              ((state == S_CALC) && alu_done);
    wr_addr = (state == S_EXEC) ? AW'(count) : AW'(count - CW'(2));
    wr_data = (state == S_EXEC) ? push_val : alu_result;
    rd_en   = (state == S_EXEC);
    rd_addr = AW'(count - CW'(2));
  end

  always_comb begin
    alu_ctrl.start = (state == S_LOAD);
    case (cmd_r)
      CMD_SUB: alu_ctrl.op = ALU_SUB;
      CMD_MUL: alu_ctrl.op = ALU_MUL;
      CMD_DIV: alu_ctrl.op = ALU_DIV;
      default: alu_ctrl.op = ALU_ADD;
    endcase
  end

  always_comb begin
    if (last_r) begin
      fin_status = ((err_latch == ST_OK) && (count != CW'(1))) ? ST_MALFORMED : err_latch;
      fin_value  = (fin_status == ST_OK) ? tos : '0;
      fin_depth  = '0;
    end else begin
      fin_status = err_latch;
      fin_value  = (count != '0) ? tos : '0;
      fin_depth  = DEPTH_W'(count);
    end
  end

  pse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pse_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .a      (rd_data),
    .b      (tos),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err_latch <= ST_OK;
      m_tvalid  <= 1'b0;
    end else begin
      // in finish a taken result is replaced by the new one below
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r     <= s_tdata[2:0];
            operand_r <= s_tdata[18:3];
            last_r    <= s_tlast;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FINISH;
          case (cmd_r)
            CMD_PUSH: begin
              if (full) begin
                err_latch <= flag(err_latch, ST_OVERFLOW);
              end else begin
                tos   <= push_val;
                count <= count + CW'(1);
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (!ops_ok) begin
                err_latch <= flag(err_latch, ST_UNDERFLOW);
              end else if ((cmd_r == CMD_DIV) && (tos == '0)) begin
                err_latch <= flag(err_latch, ST_DIVZERO);
              end else begin
                state <= S_LOAD;
              end
            end
            default: begin
              err_latch <= flag(err_latch, ST_INVALID);
            end
          endcase
        end
        S_LOAD: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (alu_done) begin
            tos   <= alu_result;
            count <= count - CW'(1);
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            value_o  <= fin_value;
            status_o <= fin_status;
            depth_o  <= fin_depth;
            m_tlast  <= last_r;
            if (last_r) begin
              count     <= '0;
              err_latch <= ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_IMPLIES(a_done_in_calc, clk, rst, alu_done, state == S_CALC, "arithmetic result outside calc")
  `ASSERT_IMPLIES(a_div_nonzero, clk, rst, alu_ctrl.start && (alu_ctrl.op == ALU_DIV), tos != '0, "divide started by zero")
  `ASSERT_NEXT(a_last_clears, clk, rst, (state == S_FINISH) && out_free && last_r, (count == '0) && (err_latch == ST_OK), "closing token left state behind")

endmodule

// File: tb/sv/postfix_stack_evaluator_core_checker.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core_checker
// tracks the operand stack from accepted tokens and checks every result
// ----------------------------------------------------------------------------
// Keeps its own Q16.16 stack, depth and first-error latch, updated on every
// accepted request. Each accepted token yields one expected result, which is
// compared field by field with the next result taken from the block. When
// closing is raised, any result still outstanding is reported as missing.
module postfix_stack_evaluator_core_checker #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [pse_pkg::S_DATA_W-1:0]  s_tdata,   // cmd[2:0], operand[18:3], zero pad
  input  logic                          s_tlast,   // last
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [pse_pkg::M_DATA_W-1:0]  m_tdata,   // value[31:0], status[34:32], depth[42:35]
  input  logic                          m_tlast,   // done_res
  input  logic                          closing,
  output int                            mismatches,
  output int                            pending,
  output int                            compared
);
  import pse_pkg::*;

  localparam int     MAX_PRINTED = 40;
  localparam longint SAT_HI      = 2147483647;
  localparam longint SAT_LO      = -SAT_HI - 1;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                done;
    logic [DEPTH_W-1:0]  depth;
  } token_result_t;

  logic [VALUE_W-1:0]  stack_mem [STACK_DEPTH];
  int                  stack_fill = 0;
  logic [STATUS_W-1:0] first_err  = ST_OK;
  token_result_t       results_due [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    compared   = 0;
  end

  function automatic logic [VALUE_W-1:0] clamp32(input longint v);
    if (v > SAT_HI) return VALUE_W'(SAT_HI);
    if (v < SAT_LO) return VALUE_W'(SAT_LO);
    return VALUE_W'(v);
  endfunction

  task automatic latch_error(input logic [STATUS_W-1:0] code);
    if (first_err == ST_OK) first_err = code;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               compared, what, got, want);
    end
    mismatches++;
  endtask

  // one accepted token moves the stack and produces one expected result
  task automatic predict_token(input logic [CMD_W-1:0] cmd, input logic [OPERAND_W-1:0] operand,
                               input logic last);
    token_result_t r;
    longint        a;
    longint        b;
    logic [VALUE_W-1:0] ans;
    logic          applied;
    r       = '0;
    ans     = '0;
    applied = 1'b1;
    if (cmd == CMD_PUSH) begin
      if (stack_fill >= STACK_DEPTH) begin
        latch_error(ST_OVERFLOW);
      end else begin
        stack_mem[stack_fill] = {operand, 16'h0000};
        stack_fill++;
      end
    end else if (cmd <= CMD_DIV) begin
      if (stack_fill < 2) begin
        latch_error(ST_UNDERFLOW);
      end else begin
        b = longint'($signed(stack_mem[stack_fill-1]));
        a = longint'($signed(stack_mem[stack_fill-2]));
        case (cmd)
          CMD_ADD: ans = clamp32(a + b);
          CMD_SUB: ans = clamp32(a - b);
          // arithmetic shift floors the 64-bit product
          CMD_MUL: ans = clamp32((a * b) >>> 16);
          default: begin
            if (b == 0) begin
              applied = 1'b0;
              latch_error(ST_DIVZERO);
            end else begin
              ans = clamp32((a * 65536) / b);
            end
          end
        endcase
        if (applied) begin
          stack_fill--;
          stack_mem[stack_fill-1] = ans;
        end
      end
    end else begin
      latch_error(ST_INVALID);
    end

    if (last) begin
      if (first_err == ST_OK && stack_fill != 1) first_err = ST_MALFORMED;
      r.status = first_err;
      if (first_err == ST_OK) r.value = stack_mem[0];
      stack_fill = 0;
      first_err  = ST_OK;
    end else begin
      r.status = first_err;
      if (stack_fill > 0) r.value = stack_mem[stack_fill-1];
    end
    r.done  = last;
    r.depth = DEPTH_W'(stack_fill);
    results_due.push_back(r);
  endtask

  task automatic check_result();
    token_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing outstanding", longint'(m_tdata), 0);
    end else begin
      want = results_due.pop_front();
      if (m_tdata[31:0] !== want.value)   report_mismatch("value", m_tdata[31:0], want.value);
      if (m_tdata[34:32] !== want.status) report_mismatch("status", m_tdata[34:32], want.status);
      if (m_tlast !== want.done)          report_mismatch("done", m_tlast, want.done);
      if (m_tdata[42:35] !== want.depth)  report_mismatch("depth", m_tdata[42:35], want.depth);
    end
    compared++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      results_due.delete();
      stack_fill = 0;
      first_err  = ST_OK;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) predict_token(s_tdata[2:0], s_tdata[18:3], s_tlast);
      if (closing) begin
        while (results_due.size() > 0) begin
          void'(results_due.pop_front());
          report_mismatch("result never delivered", 0, 0);
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// File: tb/sv/postfix_stack_evaluator_core_tb.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core_tb
// token stream stimulus and verdict for the postfix stack evaluator
// ----------------------------------------------------------------------------
// Sends a directed set of tokens (saturation, rounding, every error kind but
// overflow), then random expressions: mostly well-formed with random operands,
// some random token noise and a few that fill the stack to about full. Both
// sides idle in random bursts except in quiet stretches and at the end. The
// checker beside the block predicts and compares; this module gives the verdict.
module postfix_stack_evaluator_core_tb;
  import pse_pkg::*;

  localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CALM_TAIL    = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [CMD_W-1:0] CMD_BAD0 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD1 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD2 = 3'd7;

  localparam logic [OPERAND_W-1:0] OPND_MAX = 16'h7fff;
  localparam logic [OPERAND_W-1:0] OPND_MIN = 16'h8000;
  localparam logic [OPERAND_W-1:0] OPND_NEG1 = 16'hffff;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [OPERAND_W-1:0] operand;
    logic                 last;
  } token_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tlast;
  logic                 closing  = 1'b0;
  logic                 idle_on  = 1'b0;

  int     mismatches;
  int     pending;
  int     compared;
  int     hold_left    = 0;
  int     quiet_cycles = 0;
  int     expr_count   = 0;
  token_t token_list [$];

  postfix_stack_evaluator_core #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  postfix_stack_evaluator_core_checker #(.STACK_DEPTH(STACK_DEPTH)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .closing    (closing),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready  = 1'b0;
      hold_left = $urandom_range(0, 6);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("postfix_stack_evaluator_core_tb: FAIL");
      $finish;
    end
  end

  task automatic add_token(input logic [CMD_W-1:0] cmd, input logic [OPERAND_W-1:0] operand,
                           input logic last);
    token_t t;
    t.cmd     = cmd;
    t.operand = operand;
    t.last    = last;
    token_list.push_back(t);
    if (last) expr_count++;
  endtask

  function automatic logic [OPERAND_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return OPERAND_W'(int'($urandom_range(0, 16)) - 8);
      5:             return OPND_MAX;
      6:             return OPND_MIN;
      7:             return '0;
      default:       return OPERAND_W'($urandom);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_op();
    return CMD_W'(CMD_ADD + $urandom_range(0, 3));
  endfunction

  // well-formed postfix: n operands, n-1 operators, random tree shape
  task automatic queue_expression(input int n);
    int pushed;
    int depth_now;
    pushed    = 0;
    depth_now = 0;
    while (pushed < n || depth_now > 1) begin
      if (pushed < n && (depth_now < 2 || $urandom_range(0, 1) == 1)) begin
        add_token(CMD_PUSH, pick_operand(), 1'b0);
        pushed++;
        depth_now++;
      end else begin
        add_token(pick_op(), OPERAND_W'($urandom), 1'b0);
        depth_now--;
      end
    end
    token_list[token_list.size()-1].last = 1'b1;
    expr_count++;
  endtask

  task automatic queue_noise();
    int k;
    k = $urandom_range(1, 6);
    for (int j = 0; j < k; j++) begin
      add_token(CMD_W'($urandom_range(0, 7)), OPERAND_W'($urandom), j == k - 1);
    end
  endtask

  // fills the stack to just under, at or past full, then folds part of it back
  task automatic queue_deep_fill();
    int pushes;
    int folds;
    pushes = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
    folds  = $urandom_range(0, 6);
    for (int j = 0; j < pushes; j++) add_token(CMD_PUSH, pick_operand(), 1'b0);
    for (int j = 0; j < folds; j++) add_token(pick_op(), OPERAND_W'($urandom), 1'b0);
    add_token(CMD_ADD, '0, 1'b1);
  endtask

  task automatic send_token(input token_t t);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {(S_DATA_W-OPERAND_W-CMD_W)'(0), t.operand, t.cmd};
    s_tlast  = t.last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    int directed;
    bit calm;
    calm = 1'b0;

    // saturation on multiply and subtract, then truncating divide
    add_token(CMD_PUSH, OPND_MAX, 1'b0);
    add_token(CMD_PUSH, OPND_MAX, 1'b0);
    add_token(CMD_MUL,  '0,       1'b0);
    add_token(CMD_PUSH, OPND_MIN, 1'b0);
    add_token(CMD_SUB,  '0,       1'b0);
    add_token(CMD_PUSH, 16'd3,    1'b0);
    add_token(CMD_DIV,  '0,       1'b0);
    // divide by zero leaves the stack alone, later errors do not replace it
    add_token(CMD_PUSH, '0,       1'b0);
    add_token(CMD_DIV,  '0,       1'b0);
    add_token(CMD_BAD0, '0,       1'b0);
    add_token(CMD_ADD,  '0,       1'b1);
    // operator on an empty stack
    add_token(CMD_ADD,  '0,       1'b0);
    add_token(CMD_PUSH, 16'd5,    1'b1);
    // invalid token codes
    add_token(CMD_BAD1, OPND_MAX, 1'b0);
    add_token(CMD_BAD2, OPND_MIN, 1'b1);
    // negative saturation, negative divide and multiply by minus one
    add_token(CMD_PUSH, OPND_MIN, 1'b0);
    add_token(CMD_PUSH, OPND_MIN, 1'b0);
    add_token(CMD_ADD,  '0,       1'b0);
    add_token(CMD_PUSH, 16'd7,    1'b0);
    add_token(CMD_DIV,  '0,       1'b0);
    add_token(CMD_PUSH, OPND_NEG1, 1'b0);
    add_token(CMD_MUL,  '0,       1'b0);
    // two entries left at the end
    add_token(CMD_PUSH, 16'd2,    1'b1);
    // most negative over minus one saturates high
    add_token(CMD_PUSH, OPND_MIN, 1'b0);
    add_token(CMD_PUSH, OPND_NEG1, 1'b0);
    add_token(CMD_DIV,  '0,       1'b1);
    directed = token_list.size();

    queue_deep_fill();
    while (token_list.size() < directed + RANDOM_ITEMS) begin
      case ($urandom_range(0, 59))
        0:                        queue_deep_fill();
        1, 2, 3, 4, 5, 6:         queue_noise();
        7, 8, 9:                  queue_expression($urandom_range(9, 24));
        default:                  queue_expression($urandom_range(1, 8));
      endcase
    end

    repeat (4) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < token_list.size(); i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      idle_on = !calm && (i < token_list.size() - CALM_TAIL);
      send_token(token_list[i]);
    end
    s_tvalid = 1'b0;
    idle_on  = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    closing = 1'b1;
    @(negedge clk);

    $display("%0d tokens in %0d expressions (%0d directed tokens), %0d results compared",
             token_list.size(), expr_count, directed, compared);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("postfix_stack_evaluator_core_tb: PASS");
    end else begin
      $display("postfix_stack_evaluator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
